// ----- rtl/core/psrct_pkg.sv -----
package psrct_pkg;

  localparam int DEF_TABLE_ENTRIES = 64;

  localparam logic [1:0] OP_COUNT = 2'd0;
  localparam logic [1:0] OP_CHECK = 2'd1;
  localparam logic [1:0] OP_SWEEP = 2'd2;

  localparam logic CFG_WINDOW = 1'b0;
  localparam logic CFG_LIMIT  = 1'b1;

  localparam logic [15:0] WINDOW_RESET = 16'd10;
  localparam logic [15:0] LIMIT_RESET  = 16'd100;

  typedef struct packed {
    logic        valid;
    logic        is_v6;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [15:0] counter;
    logic [15:0] prev_counter;
    logic [31:0] window_start;
  } entry_t;

  typedef struct packed {
    logic clear_wr;
    logic idx_clr;
    logic idx_inc;
    logic load;
    logic rd;
    logic probe;
    logic sweep_wr;
    logic commit;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic last;
    logic match;
  } sts_t;

  function automatic entry_t apply_window(entry_t e, logic [31:0] now, logic [15:0] win,
                                          logic [15:0] lim, logic add);
    entry_t      r;
    logic [31:0] elapsed;
    logic [15:0] c;
    logic [16:0] s;
    r       = e;
    elapsed = now - e.window_start;
    c       = e.counter;
    if (elapsed > {16'b0, win}) begin
      r.window_start = now;
      c = (e.counter >= e.prev_counter) ? e.counter - e.prev_counter : 16'd0;
      r.prev_counter = c;
    end
    s = {1'b0, c} + {16'b0, add};
    if (s > {1'b0, lim}) begin
      s = {1'b0, lim};
    end
    r.counter = s[15:0];
    return r;
  endfunction

endpackage

// ----- rtl/core/psrct_ctrl.sv -----
module psrct_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        operation,
  input  psrct_pkg::sts_t   sts,
  output psrct_pkg::ctl_t   ctl,
  output logic              busy
);
  import psrct_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_READ   = 6'b000100,
    S_CHECK  = 6'b001000,
    S_UPDATE = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] op;
  logic [1:0] op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      op    <= OP_COUNT;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    op_next    = op;
    ctl        = '0;
    unique case (state)
      S_CLEAR: begin
        ctl.clear_wr = 1'b1;
        if (sts.last) begin
          ctl.idx_clr = 1'b1;
          state_next  = S_IDLE;
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          ctl.load    = 1'b1;
          ctl.idx_clr = 1'b1;
          op_next     = operation;
          if (operation == OP_COUNT || operation == OP_CHECK || operation == OP_SWEEP) begin
            state_next = S_READ;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_READ: begin
        ctl.rd     = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (op == OP_SWEEP) begin
          ctl.sweep_wr = 1'b1;
          if (sts.last) begin
            state_next = S_DONE;
          end else begin
            ctl.idx_inc = 1'b1;
            state_next  = S_READ;
          end
        end else begin
          ctl.probe = 1'b1;
          if (sts.match || sts.last) begin
            state_next = (op == OP_COUNT) ? S_UPDATE : S_DONE;
          end else begin
            ctl.idx_inc = 1'b1;
            state_next  = S_READ;
          end
        end
      end
      S_UPDATE: begin
        ctl.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        ctl.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/psrct_datapath.sv -----
module psrct_datapath #(
  parameter int TABLE_ENTRIES = psrct_pkg::DEF_TABLE_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  psrct_pkg::ctl_t   ctl,
  output psrct_pkg::sts_t   sts,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic [1:0]        operation,
  input  logic              address_is_v6,
  input  logic [63:0]       key_high,
  input  logic [63:0]       key_low,
  input  logic [31:0]       now_seconds,
  output logic              done,
  output logic              allowed,
  output logic [15:0]       count_value,
  output logic              table_full
);
  import psrct_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  entry_t         mem [TABLE_ENTRIES];
  entry_t         rd_q;
  entry_t         base;
  logic [15:0]    window_len;
  logic [15:0]    limit;
  logic [IW-1:0]  idx;
  logic [IW-1:0]  tgt;
  logic [1:0]     op_q;
  logic           v6_q;
  logic [63:0]    hi_q;
  logic [63:0]    lo_q;
  logic [31:0]    now_q;
  logic           hit;
  logic           free_found;
  logic [15:0]    count_res;
  logic           full_res;

  entry_t         fresh;
  entry_t         upd_src;
  entry_t         applied;
  entry_t         swept;
  logic           mem_we;
  logic [IW-1:0]  mem_waddr;
  entry_t         mem_wdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_RESET;
      limit      <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW: window_len <= cfg_data;
        CFG_LIMIT:  limit      <= cfg_data;
        default:    limit      <= limit;
      endcase
    end
  end

  assign sts.last  = (idx == LAST_IDX);
  assign sts.match = rd_q.valid && (rd_q.is_v6 == v6_q) &&
                     (rd_q.key_high == hi_q) && (rd_q.key_low == lo_q);

  always_comb begin
    fresh              = '0;
    fresh.valid        = 1'b1;
    fresh.is_v6        = v6_q;
    fresh.key_high     = hi_q;
    fresh.key_low      = lo_q;
    upd_src            = hit ? base : fresh;
    applied            = apply_window(upd_src, now_q, window_len, limit, 1'b1);
    swept              = apply_window(rd_q, now_q, window_len, limit, 1'b0);
    swept.valid        = (swept.counter != 16'd0);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = '0;
    priority if (ctl.clear_wr) begin
      mem_we = 1'b1;
    end else if (ctl.sweep_wr) begin
      mem_we    = rd_q.valid;
      mem_wdata = swept;
    end else if (ctl.commit) begin
      mem_we    = hit || free_found;
      mem_waddr = tgt;
      mem_wdata = applied;
    end else begin
      mem_we = 1'b0;
    end
  end

  // entry table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (ctl.rd) begin
      rd_q <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (ctl.idx_clr) begin
      idx <= '0;
    end else if (ctl.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  // latched beat and lookup results
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_q  <= operation;
      v6_q  <= address_is_v6;
      hi_q  <= address_is_v6 ? key_high : 64'd0;
      lo_q  <= address_is_v6 ? key_low : {32'd0, key_low[31:0]};
      now_q <= now_seconds;
    end
    if (ctl.probe && sts.match) begin
      base <= rd_q;
    end
    if (ctl.probe && (sts.match || (!rd_q.valid && !free_found && !hit))) begin
      tgt <= idx;
    end
    if (ctl.commit) begin
      count_res <= (hit || free_found) ? applied.counter : 16'd0;
      full_res  <= !(hit || free_found);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (ctl.load) begin
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else if (ctl.probe) begin
      if (sts.match) begin
        hit <= 1'b1;
      end else if (!rd_q.valid) begin
        free_found <= 1'b1;
      end
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.finish;
    end
    if (ctl.finish) begin
      allowed     <= !((op_q == OP_CHECK) && hit && (base.counter >= limit));
      table_full  <= (op_q == OP_COUNT) && full_res;
      if (op_q == OP_COUNT) begin
        count_value <= count_res;
      end else if ((op_q == OP_CHECK) && hit) begin
        count_value <= base.counter;
      end else begin
        count_value <= 16'd0;
      end
    end
  end

endmodule

// ----- rtl/core/per_source_rate_counter_table.sv -----
// channel   signals                                             dir
// cfg       cfg_we, cfg_index, cfg_data                         in
// command   start, busy, operation, address_is_v6, key_high,    in
//           key_low, now_seconds
// result    done, allowed, count_value, table_full              out
//
// after reset a clearing pass over all TABLE_ENTRIES entries runs with busy high
// each probed entry is read from memory, then compared or written back
// count: probes until a match or the last entry, then commits the update
// check: probes the same way with no update; sweep: every entry; unused code: none
// result beat is on the ports for one cycle with done high; receiver cannot stall
module per_source_rate_counter_table #(
  parameter int TABLE_ENTRIES = psrct_pkg::DEF_TABLE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic        address_is_v6,
  input  logic [63:0] key_high,
  input  logic [63:0] key_low,
  input  logic [31:0] now_seconds,
  output logic        done,
  output logic        allowed,
  output logic [15:0] count_value,
  output logic        table_full
);
  import psrct_pkg::*;

  ctl_t ctl;
  sts_t sts;

  psrct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .sts       (sts),
    .ctl       (ctl),
    .busy      (busy)
  );

  psrct_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .operation     (operation),
    .address_is_v6 (address_is_v6),
    .key_high      (key_high),
    .key_low       (key_low),
    .now_seconds   (now_seconds),
    .done          (done),
    .allowed       (allowed),
    .count_value   (count_value),
    .table_full    (table_full)
  );

endmodule

// ----- tb/sv/per_source_rate_counter_table_tb.sv -----
typedef struct {
  bit        used;
  bit        v6;
  bit [63:0] hi;
  bit [63:0] lo;
  bit [15:0] cnt;
  bit [15:0] prev;
  bit [31:0] since;
} tally_slot_t;

typedef struct {
  bit        allowed;
  bit [15:0] count;
  bit        full;
} outcome_t;

class source_counter_tally;
  bit [15:0]   window_len;
  bit [15:0]   limit;
  tally_slot_t slot[psrct_pkg::DEF_TABLE_ENTRIES];
  outcome_t    due_outcomes[$];
  int          errors;

  function new();
    window_len = psrct_pkg::WINDOW_RESET;
    limit      = psrct_pkg::LIMIT_RESET;
    foreach (slot[i]) slot[i].used = 1'b0;
    errors = 0;
  endfunction

  function void set_reg(logic idx, logic [15:0] value);
    if (idx == psrct_pkg::CFG_WINDOW) begin
      window_len = value;
    end else begin
      limit = value;
    end
  endfunction

  function int find_slot(bit v6, bit [63:0] hi, bit [63:0] lo);
    for (int i = 0; i < psrct_pkg::DEF_TABLE_ENTRIES; i++) begin
      if (slot[i].used && slot[i].v6 == v6 && slot[i].hi == hi && slot[i].lo == lo) begin
        return i;
      end
    end
    return -1;
  endfunction

  function int free_slot();
    for (int i = 0; i < psrct_pkg::DEF_TABLE_ENTRIES; i++) begin
      if (!slot[i].used) begin
        return i;
      end
    end
    return -1;
  endfunction

  function void roll_window(int e, bit [31:0] now, bit bump);
    bit [31:0] elapsed;
    bit [15:0] c;
    bit [16:0] s;
    elapsed = now - slot[e].since;
    if (elapsed > {16'd0, window_len}) begin
      slot[e].since = now;
      c = (slot[e].cnt >= slot[e].prev) ? slot[e].cnt - slot[e].prev : 16'd0;
      slot[e].cnt  = c;
      slot[e].prev = c;
    end
    s = {1'b0, slot[e].cnt} + {16'd0, bump};
    if (s > {1'b0, limit}) begin
      s = {1'b0, limit};
    end
    slot[e].cnt = s[15:0];
  endfunction

  function void note_command(logic [1:0] op, logic v6, logic [63:0] hi_in,
                             logic [63:0] lo_in, logic [31:0] now);
    outcome_t  exp;
    int        e;
    bit [63:0] hi;
    bit [63:0] lo;
    hi          = v6 ? hi_in : 64'd0;
    lo          = v6 ? lo_in : {32'd0, lo_in[31:0]};
    exp.allowed = 1'b1;
    exp.count   = 16'd0;
    exp.full    = 1'b0;
    case (op)
      psrct_pkg::OP_COUNT: begin
        e = find_slot(v6, hi, lo);
        if (e < 0) begin
          e = free_slot();
          if (e < 0) begin
            exp.full = 1'b1;
          end else begin
            slot[e].used  = 1'b1;
            slot[e].v6    = v6;
            slot[e].hi    = hi;
            slot[e].lo    = lo;
            slot[e].cnt   = 16'd0;
            slot[e].prev  = 16'd0;
            slot[e].since = 32'd0;
          end
        end
        if (e >= 0) begin
          roll_window(e, now, 1'b1);
          exp.count = slot[e].cnt;
        end
      end
      psrct_pkg::OP_CHECK: begin
        e = find_slot(v6, hi, lo);
        if (e >= 0) begin
          exp.count = slot[e].cnt;
          if (slot[e].cnt >= limit) begin
            exp.allowed = 1'b0;
          end
        end
      end
      psrct_pkg::OP_SWEEP: begin
        for (int i = 0; i < psrct_pkg::DEF_TABLE_ENTRIES; i++) begin
          if (slot[i].used) begin
            roll_window(i, now, 1'b0);
            if (slot[i].cnt == 16'd0) begin
              slot[i].used = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase
    due_outcomes.push_back(exp);
  endfunction

  function void check_outcome(longint unsigned stamp, logic a, logic [15:0] c, logic f);
    outcome_t exp;
    if (due_outcomes.size() == 0) begin
      errors++;
      $display("%0d ns: result beat with nothing expected, allowed %0b count %0d full %0b",
               stamp, a, c, f);
      return;
    end
    exp = due_outcomes.pop_front();
    if (a !== exp.allowed) begin
      errors++;
      $display("%0d ns: allowed expected %0b actual %0b", stamp, exp.allowed, a);
    end
    if (c !== exp.count) begin
      errors++;
      $display("%0d ns: count_value expected %0d actual %0d", stamp, exp.count, c);
    end
    if (f !== exp.full) begin
      errors++;
      $display("%0d ns: table_full expected %0b actual %0b", stamp, exp.full, f);
    end
  endfunction

  function int pending();
    return due_outcomes.size();
  endfunction
endclass

module per_source_rate_counter_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         POOL_MAX  = 72;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = 16'd0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation = 2'd0;
  logic        address_is_v6 = 1'b0;
  logic [63:0] key_high = 64'd0;
  logic [63:0] key_low = 64'd0;
  logic [31:0] now_seconds = 32'd0;
  logic        done;
  logic        allowed;
  logic [15:0] count_value;
  logic        table_full;

  source_counter_tally tally;
  logic [31:0]         cur_now = 32'd0;
  logic                no_gaps = 1'b0;
  int                  pool_n = 1;
  logic                pool_v6[POOL_MAX];
  logic [63:0]         pool_hi[POOL_MAX];
  logic [63:0]         pool_lo[POOL_MAX];

  per_source_rate_counter_table dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .address_is_v6(address_is_v6),
    .key_high     (key_high),
    .key_low      (key_low),
    .now_seconds  (now_seconds),
    .done         (done),
    .allowed      (allowed),
    .count_value  (count_value),
    .table_full   (table_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      tally.check_outcome($time, allowed, count_value, table_full);
    end
  end

  initial begin
    #15_000_000;
    $display("per_source_rate_counter_table_tb: errors");
    $finish;
  end

  task automatic write_reg(input logic idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    tally.set_reg(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    do @(posedge clk); while (tally.pending() != 0 || busy);
  endtask

  task automatic issue(input logic [1:0] op, input logic v6, input logic [63:0] hi,
                       input logic [63:0] lo, input logic [31:0] now);
    int gap;
    @(negedge clk);
    start         = 1'b1;
    operation     = op;
    address_is_v6 = v6;
    key_high      = hi;
    key_low       = lo;
    now_seconds   = now;
    do @(posedge clk); while (busy);
    tally.note_command(op, v6, hi, lo, now);
    gap = no_gaps ? 0 : int'($urandom_range(0, 12));
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic random_item();
    int          pick;
    int          k;
    logic [1:0]  op;
    logic        v6;
    logic [63:0] hi;
    logic [63:0] lo;
    case ($urandom_range(0, 15))
      0: cur_now = $urandom;
      1: cur_now = cur_now - $urandom_range(1, 20);
      default: cur_now = cur_now + $urandom_range(0, 3);
    endcase
    pick = int'($urandom_range(0, 99));
    k    = int'($urandom_range(0, pool_n - 1));
    v6   = pool_v6[k];
    hi   = v6 ? pool_hi[k] : {$urandom, $urandom};
    lo   = v6 ? pool_lo[k] : {$urandom, pool_lo[k][31:0]};
    if (pick < 60) begin
      op = psrct_pkg::OP_COUNT;
    end else if (pick < 85) begin
      op = psrct_pkg::OP_CHECK;
    end else if (pick < 90) begin
      // probe for a key that is almost surely unknown
      op = psrct_pkg::OP_CHECK;
      v6 = 1'($urandom_range(0, 1));
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
    end else if (pick < 95) begin
      op = psrct_pkg::OP_SWEEP;
    end else begin
      op = OP_UNUSED;
    end
    issue(op, v6, hi, lo, cur_now);
  endtask

  initial begin
    int          ph;
    int          k;
    logic [15:0] win;
    logic [15:0] lim;
    logic [63:0] v4key;
    logic [63:0] ones;
    tally = new();
    v4key = 64'h0000_0000_c0a8_0001;
    ones  = {64{1'b1}};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (2) @(posedge clk);
    settle();

    // reset settings: lookup, insert, ipv4 masking, ipv6 alias, time wrap
    issue(psrct_pkg::OP_CHECK, 1'b0, ones, v4key, 32'd5);
    issue(psrct_pkg::OP_COUNT, 1'b0, ones, {32'hffff_ffff, v4key[31:0]}, 32'd5);
    issue(psrct_pkg::OP_COUNT, 1'b0, 64'd0, v4key, 32'd6);
    issue(psrct_pkg::OP_COUNT, 1'b1, 64'd0, v4key, 32'd6);
    issue(psrct_pkg::OP_COUNT, 1'b1, ones, ones, 32'hffff_ffff);
    issue(psrct_pkg::OP_COUNT, 1'b1, ones, ones, 32'd2);
    issue(psrct_pkg::OP_CHECK, 1'b1, ones, ones, 32'd2);
    issue(OP_UNUSED, 1'b1, ones, ones, 32'hffff_ffff);
    issue(OP_UNUSED, 1'b0, 64'd0, 64'd0, 32'd0);
    issue(psrct_pkg::OP_SWEEP, 1'b0, 64'd0, 64'd0, 32'd3);

    // saturation at a small limit
    settle();
    write_reg(psrct_pkg::CFG_WINDOW, 16'd0);
    write_reg(psrct_pkg::CFG_LIMIT, 16'd3);
    repeat (4) issue(psrct_pkg::OP_COUNT, 1'b0, 64'd0, v4key, 32'd6);
    issue(psrct_pkg::OP_CHECK, 1'b0, 64'd0, v4key, 32'd6);

    // limit dropped under the recorded count
    settle();
    write_reg(psrct_pkg::CFG_LIMIT, 16'hffff);
    repeat (3) issue(psrct_pkg::OP_COUNT, 1'b0, 64'd0, v4key, 32'd7);
    issue(psrct_pkg::OP_COUNT, 1'b0, 64'd0, v4key, 32'd8);
    settle();
    write_reg(psrct_pkg::CFG_LIMIT, 16'd1);
    issue(psrct_pkg::OP_COUNT, 1'b0, 64'd0, v4key, 32'd8);
    issue(psrct_pkg::OP_COUNT, 1'b0, 64'd0, v4key, 32'd9);

    // zero limit, then a sweep that frees everything
    settle();
    write_reg(psrct_pkg::CFG_LIMIT, 16'd0);
    issue(psrct_pkg::OP_COUNT, 1'b0, 64'd0, v4key, 32'd9);
    issue(psrct_pkg::OP_CHECK, 1'b0, 64'd0, v4key, 32'd9);
    issue(psrct_pkg::OP_SWEEP, 1'b1, ones, ones, 32'd10);
    issue(psrct_pkg::OP_CHECK, 1'b0, 64'd0, v4key, 32'd10);
    cur_now = 32'd10;

    for (ph = 0; ph < 12; ph++) begin
      settle();
      if (ph == 0) begin
        win = 16'hffff;
        lim = 16'hffff;
      end else if (ph == 1) begin
        win = 16'd0;
        lim = 16'd1;
      end else begin
        case ($urandom_range(0, 4))
          0: win = 16'd0;
          1: win = 16'd1;
          2: win = 16'($urandom_range(2, 40));
          3: win = 16'hffff;
          default: win = 16'($urandom);
        endcase
        case ($urandom_range(0, 5))
          0: lim = 16'd0;
          1: lim = 16'd1;
          2: lim = 16'($urandom_range(2, 6));
          3: lim = 16'd100;
          4: lim = 16'hffff;
          default: lim = 16'($urandom);
        endcase
      end
      write_reg(psrct_pkg::CFG_WINDOW, win);
      write_reg(psrct_pkg::CFG_LIMIT, lim);
      case (ph % 4)
        0: pool_n = 3;
        1: pool_n = 12;
        2: pool_n = 30;
        default: pool_n = POOL_MAX;
      endcase
      for (k = 0; k < pool_n; k++) begin
        pool_v6[k] = 1'($urandom_range(0, 1));
        pool_hi[k] = {$urandom, $urandom};
        pool_lo[k] = {$urandom, $urandom};
      end
      no_gaps = (ph % 4 == 1);
      // more keys than entries: drive the table full
      if (pool_n == POOL_MAX) begin
        for (k = 0; k < pool_n; k++) begin
          issue(psrct_pkg::OP_COUNT, pool_v6[k], pool_hi[k], pool_lo[k], cur_now);
        end
      end
      repeat (135) random_item();
    end

    settle();
    repeat (2 * psrct_pkg::DEF_TABLE_ENTRIES + 8) @(posedge clk);
    if (tally.errors == 0 && tally.pending() == 0) begin
      $display("per_source_rate_counter_table_tb: clean");
    end else begin
      $display("per_source_rate_counter_table_tb: errors");
    end
    $finish;
  end
endmodule
